// ===== rtl/core/trqs_pkg.sv =====
// ----------------------------------------------------------------------------
// trqs_pkg
// shared constants, codes and result beat type of the timer and ready queue
// scheduler
// ----------------------------------------------------------------------------
package trqs_pkg;

    localparam int POOL_ENTRIES_DEF = 16;
    localparam int TICK_BITS_DEF    = 32;
    localparam int TOKEN_BITS_DEF   = 16;
    localparam int ARG_BITS_DEF     = 32;

    // operation codes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_POST      = 3'd1;
    localparam logic [2:0] OP_POST_DLY  = 3'd2;
    localparam logic [2:0] OP_EMIT      = 3'd3;
    localparam logic [2:0] OP_CANCEL    = 3'd4;
    localparam logic [2:0] OP_RUN       = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_TASK    = 2'd1;
    localparam logic [1:0] KIND_EVENT   = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NULL_HND  = 2'd1;
    localparam logic [1:0] ST_POOL_FULL = 2'd2;

    // entry kinds
    localparam logic ENT_TASK  = 1'b0;
    localparam logic ENT_EVENT = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] handler;
        logic [15:0] out_evt;
        logic [31:0] argument;
        logic        release_arg;
        logic [5:0]  cancel_count;
        logic [31:0] sleep_len;
        logic        last;
    } t_result;

endpackage

// ===== rtl/core/timer_and_ready_queue_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// timer_and_ready_queue_scheduler_core
// event loop scheduler over a fixed entry pool: free list, fifo ready queue
// and expiry-sorted timer list, all linked through one entry store
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall) carries one command beat:
//   tick, post, post delayed, emit event, cancel or run
//   output channel (o_out_valid / i_out_stall) carries result beats; the
//   final beat of each command has o_last set; unused op codes give none
//   o_in_stall is high while a command is in work, one command at a time
// walks
//   post delayed walks the timer list to its place, cancel walks both
//   lists, run moves due timers to the ready tail and then walks the ready
//   queue; each walk step is one read of the store
// reset
//   synchronous, active low; all lists empty, every entry free, tick zero;
//   no clearing pass, link chain comes from per-entry valid bits
// stall
//   a stalled result beat holds; the sequencer waits on it and the command
//   channel stays stalled until the last beat is loaded, not until it is handed over
// ----------------------------------------------------------------------------
module timer_and_ready_queue_scheduler_core #(
    parameter int POOL_ENTRIES = trqs_pkg::POOL_ENTRIES_DEF,
    parameter int TICK_BITS    = trqs_pkg::TICK_BITS_DEF,
    parameter int TOKEN_BITS   = trqs_pkg::TOKEN_BITS_DEF,
    parameter int ARG_BITS     = trqs_pkg::ARG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_handler_id,
    input  logic [15:0] i_event_id,
    input  logic [31:0] i_argument,
    input  logic [31:0] i_delay_ticks,
    input  logic        i_managed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_handler,
    output logic [15:0] o_out_event,
    output logic [31:0] o_out_argument,
    output logic        o_release_arg,
    output logic [5:0]  o_cancel_count,
    output logic [31:0] o_sleep_ticks,
    output logic        o_last
);

    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int PW = $clog2(POOL_ENTRIES + 1);
    localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

    typedef enum logic [4:0] {
        S_IDLE, S_EMIT, S_ALLOC_RD, S_ALLOC_WR, S_APPEND,
        S_INS_RD, S_INS_CHK, S_INS_LINK, S_INS_PREV,
        S_CAN_RD, S_CAN_CHK, S_CAN_FREE,
        S_RUN_TRD, S_RUN_TCHK, S_RUN_TAPP, S_RUN_RRD, S_RUN_RDIS,
        S_RUN_SRD, S_RUN_SUM
    } t_state;

    t_state r_state;

    // command registers
    logic [2:0]            r_op;
    logic [TOKEN_BITS-1:0] r_hnd;
    logic [TOKEN_BITS-1:0] r_evt;
    logic [ARG_BITS-1:0]   r_arg;
    logic                  r_mgd;
    logic [TICK_BITS-1:0]  r_exp;

    // list heads and walk pointers
    logic [PW-1:0]        r_fhead, r_rhead, r_rtail, r_thead;
    logic [PW-1:0]        r_prev, r_cur, r_ent;
    logic                 r_list;     // cancel: 0 timer list, 1 ready list
    logic [5:0]           r_cnt;
    logic [TICK_BITS-1:0] r_now;

    trqs_pkg::t_result r_pend, r_out;
    trqs_pkg::t_result n_pend, n_disp;
    logic              r_ovalid;

    // store ports
    logic                  m_d_we, m_l_we, m_re;
    logic [AW-1:0]         m_d_addr, m_l_addr, m_raddr;
    logic [PW-1:0]         m_l_link;
    logic                  q_kind, q_managed;
    logic [TOKEN_BITS-1:0] q_token;
    logic [ARG_BITS-1:0]   q_arg;
    logic [TICK_BITS-1:0]  q_expiry;
    logic [PW-1:0]         q_link;

    logic                 can_emit, emit_fire, in_acc, is_evt, match;
    logic [TICK_BITS-1:0] d_ins, d_due, d_sleep;

    trqs_mem #(
        .POOL_ENTRIES(POOL_ENTRIES), .TICK_BITS(TICK_BITS),
        .TOKEN_BITS(TOKEN_BITS), .ARG_BITS(ARG_BITS)
    ) u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_d_we(m_d_we), .i_d_addr(m_d_addr),
        .i_d_kind(is_evt ? trqs_pkg::ENT_EVENT : trqs_pkg::ENT_TASK),
        .i_d_token(is_evt ? r_evt : r_hnd), .i_d_arg(r_arg),
        .i_d_managed(is_evt & r_mgd), .i_d_expiry(r_exp),
        .i_l_we(m_l_we), .i_l_addr(m_l_addr), .i_l_link(m_l_link),
        .i_re(m_re), .i_raddr(m_raddr),
        .o_kind(q_kind), .o_token(q_token), .o_arg(q_arg),
        .o_managed(q_managed), .o_expiry(q_expiry), .o_link(q_link)
    );

    assign is_evt    = (r_op == trqs_pkg::OP_EMIT);
    assign can_emit  = !r_ovalid || !i_out_stall;
    assign emit_fire = can_emit && (r_state == S_EMIT || r_state == S_RUN_RDIS);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // wrap-safe differences
    assign d_ins   = q_expiry - r_exp;
    assign d_due   = r_now - q_expiry;
    assign d_sleep = q_expiry - r_now;
    assign match   = (q_kind == trqs_pkg::ENT_TASK) && (q_token == r_hnd) && (q_arg == r_arg);

    // status beat prepared at command accept; run starts as an empty summary
    always_comb begin
        n_pend      = '0;
        n_pend.last = 1'b1;
        case (i_operation)
            trqs_pkg::OP_POST, trqs_pkg::OP_POST_DLY: begin
                if (TOKEN_BITS'(i_handler_id) == '0) begin
                    n_pend.status = trqs_pkg::ST_NULL_HND;
                end else if (r_fhead == NIL) begin
                    n_pend.status = trqs_pkg::ST_POOL_FULL;
                end
            end
            trqs_pkg::OP_EMIT: begin
                if (r_fhead == NIL) begin
                    // pool full: event goes back with its argument
                    n_pend.status      = trqs_pkg::ST_POOL_FULL;
                    n_pend.out_evt     = 16'(TOKEN_BITS'(i_event_id));
                    n_pend.argument    = 32'(ARG_BITS'(i_argument));
                    n_pend.release_arg = i_managed;
                end
            end
            trqs_pkg::OP_CANCEL: begin
                if (TOKEN_BITS'(i_handler_id) == '0) begin
                    n_pend.status = trqs_pkg::ST_NULL_HND;
                end
            end
            trqs_pkg::OP_RUN: begin
                n_pend.kind      = trqs_pkg::KIND_SUMMARY;
                n_pend.sleep_len = 32'({TICK_BITS{1'b1}});
            end
            default: ;
        endcase
    end

    // dispatch beat of the ready entry just read
    always_comb begin
        n_disp = '0;
        if (q_kind == trqs_pkg::ENT_TASK) begin
            n_disp.kind    = trqs_pkg::KIND_TASK;
            n_disp.handler = 16'(q_token);
        end else begin
            n_disp.kind        = trqs_pkg::KIND_EVENT;
            n_disp.out_evt     = 16'(q_token);
            n_disp.release_arg = q_managed;
        end
        n_disp.argument = 32'(q_arg);
    end

    // store access per state; reads and writes never share a cycle
    always_comb begin
        m_d_we   = 1'b0;
        m_l_we   = 1'b0;
        m_re     = 1'b0;
        m_d_addr = r_ent[AW-1:0];
        m_l_addr = r_ent[AW-1:0];
        m_l_link = NIL;
        m_raddr  = r_cur[AW-1:0];
        case (r_state)
            S_ALLOC_RD: begin
                m_re    = 1'b1;
                m_raddr = r_fhead[AW-1:0];
            end
            S_ALLOC_WR: begin
                m_d_we = 1'b1;
                m_l_we = 1'b1;
            end
            S_APPEND, S_RUN_TAPP: begin
                m_l_we   = (r_rtail != NIL);
                m_l_addr = r_rtail[AW-1:0];
                m_l_link = r_ent;
            end
            S_INS_RD, S_CAN_RD, S_RUN_RRD: begin
                m_re = (r_cur != NIL);
            end
            S_INS_LINK: begin
                m_l_we   = 1'b1;
                m_l_link = r_cur;
            end
            S_INS_PREV: begin
                m_l_we   = 1'b1;
                m_l_addr = r_prev[AW-1:0];
                m_l_link = r_ent;
            end
            S_CAN_CHK: begin
                m_l_we   = match && (r_prev != NIL);
                m_l_addr = r_prev[AW-1:0];
                m_l_link = q_link;
            end
            S_CAN_FREE: begin
                m_l_we   = 1'b1;
                m_l_link = r_fhead;
            end
            S_RUN_TRD, S_RUN_SRD: begin
                m_re    = (r_thead != NIL);
                m_raddr = r_thead[AW-1:0];
            end
            S_RUN_TCHK: begin
                m_l_we   = !d_due[TICK_BITS-1];
                m_l_addr = r_thead[AW-1:0];
            end
            S_RUN_RDIS: begin
                m_l_we   = can_emit;
                m_l_addr = r_cur[AW-1:0];
                m_l_link = r_fhead;
            end
            default: ;
        endcase
    end

    // result register valid: set on a loaded beat, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit_fire) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fhead  <= '0;
            r_rhead  <= NIL;
            r_rtail  <= NIL;
            r_thead  <= NIL;
            r_now    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op   <= i_operation;
                        r_hnd  <= TOKEN_BITS'(i_handler_id);
                        r_evt  <= TOKEN_BITS'(i_event_id);
                        r_arg  <= ARG_BITS'(i_argument);
                        r_mgd  <= i_managed;
                        r_exp  <= r_now + TICK_BITS'(i_delay_ticks);
                        r_pend <= n_pend;
                        r_cnt  <= '0;
                        r_prev <= NIL;
                        r_list <= 1'b0;
                        r_cur  <= r_thead;
                        case (i_operation)
                            trqs_pkg::OP_TICK: begin
                                r_now   <= r_now + TICK_BITS'(1);
                                r_state <= S_EMIT;
                            end
                            trqs_pkg::OP_POST, trqs_pkg::OP_POST_DLY: begin
                                if (TOKEN_BITS'(i_handler_id) == '0 || r_fhead == NIL) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_ALLOC_RD;
                                end
                            end
                            trqs_pkg::OP_EMIT: begin
                                r_state <= (r_fhead == NIL) ? S_EMIT : S_ALLOC_RD;
                            end
                            trqs_pkg::OP_CANCEL: begin
                                if (TOKEN_BITS'(i_handler_id) == '0) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_CAN_RD;
                                end
                            end
                            trqs_pkg::OP_RUN: r_state <= S_RUN_TRD;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (can_emit) begin
                        r_out   <= r_pend;
                        r_state <= S_IDLE;
                    end
                end
                // allocation from the free list head
                S_ALLOC_RD: begin
                    r_ent   <= r_fhead;
                    r_state <= S_ALLOC_WR;
                end
                S_ALLOC_WR: begin
                    r_fhead <= q_link;
                    r_prev  <= NIL;
                    r_cur   <= r_thead;
                    r_state <= (r_op == trqs_pkg::OP_POST_DLY) ? S_INS_RD : S_APPEND;
                end
                S_APPEND: begin
                    if (r_rtail == NIL) begin
                        r_rhead <= r_ent;
                    end
                    r_rtail <= r_ent;
                    r_state <= S_EMIT;
                end
                // sorted insert, equal expiries stay ahead
                S_INS_RD: begin
                    r_state <= (r_cur == NIL) ? S_INS_LINK : S_INS_CHK;
                end
                S_INS_CHK: begin
                    if (d_ins != '0 && !d_ins[TICK_BITS-1]) begin
                        r_state <= S_INS_LINK;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= q_link;
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_LINK: begin
                    if (r_prev == NIL) begin
                        r_thead <= r_ent;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_INS_PREV;
                    end
                end
                S_INS_PREV: r_state <= S_EMIT;
                // cancel walk: timer list, then ready list
                S_CAN_RD: begin
                    if (r_cur != NIL) begin
                        r_state <= S_CAN_CHK;
                    end else if (!r_list) begin
                        r_list <= 1'b1;
                        r_prev <= NIL;
                        r_cur  <= r_rhead;
                    end else begin
                        // last kept entry becomes the ready tail
                        r_rtail             <= r_prev;
                        r_pend.cancel_count <= r_cnt;
                        r_state             <= S_EMIT;
                    end
                end
                S_CAN_CHK: begin
                    r_cur <= q_link;
                    if (match) begin
                        if (r_prev == NIL) begin
                            if (r_list) begin
                                r_rhead <= q_link;
                            end else begin
                                r_thead <= q_link;
                            end
                        end
                        r_ent   <= r_cur;
                        r_cnt   <= r_cnt + 6'd1;
                        r_state <= S_CAN_FREE;
                    end else begin
                        r_prev  <= r_cur;
                        r_state <= S_CAN_RD;
                    end
                end
                S_CAN_FREE: begin
                    r_fhead <= r_ent;
                    r_state <= S_CAN_RD;
                end
                // run: due timers to the ready tail
                S_RUN_TRD: begin
                    if (r_thead == NIL) begin
                        r_cur   <= r_rhead;
                        r_rhead <= NIL;
                        r_rtail <= NIL;
                        r_state <= S_RUN_RRD;
                    end else begin
                        r_state <= S_RUN_TCHK;
                    end
                end
                S_RUN_TCHK: begin
                    if (d_due[TICK_BITS-1]) begin
                        r_cur   <= r_rhead;
                        r_rhead <= NIL;
                        r_rtail <= NIL;
                        r_state <= S_RUN_RRD;
                    end else begin
                        r_ent   <= r_thead;
                        r_thead <= q_link;
                        r_state <= S_RUN_TAPP;
                    end
                end
                S_RUN_TAPP: begin
                    if (r_rtail == NIL) begin
                        r_rhead <= r_ent;
                    end
                    r_rtail <= r_ent;
                    r_state <= S_RUN_TRD;
                end
                // run: dispatch and free the ready queue
                S_RUN_RRD: begin
                    r_state <= (r_cur == NIL) ? S_RUN_SRD : S_RUN_RDIS;
                end
                S_RUN_RDIS: begin
                    if (can_emit) begin
                        r_out   <= n_disp;
                        r_fhead <= r_cur;
                        r_cur   <= q_link;
                        r_state <= S_RUN_RRD;
                    end
                end
                S_RUN_SRD: begin
                    // no timer pending keeps the all-ones sleep
                    r_state <= (r_thead == NIL) ? S_EMIT : S_RUN_SUM;
                end
                S_RUN_SUM: begin
                    r_pend.sleep_len <= (d_sleep != '0 && !d_sleep[TICK_BITS-1])
                                        ? 32'(d_sleep) : 32'd0;
                    r_state <= S_EMIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_kind         = r_out.kind;
    assign o_status       = r_out.status;
    assign o_out_handler  = r_out.handler;
    assign o_out_event    = r_out.out_evt;
    assign o_out_argument = r_out.argument;
    assign o_release_arg  = r_out.release_arg;
    assign o_cancel_count = r_out.cancel_count;
    assign o_sleep_ticks  = r_out.sleep_len;
    assign o_last         = r_out.last;

    // ready queue head and tail are empty together between commands
    a_ready_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_rhead == NIL) == (r_rtail == NIL)))
        else $error("ready head and tail disagree on empty");

    // free list head is always an entry or null
    a_free_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fhead <= NIL)
        else $error("free head out of range");

    // cancel never removes more than the pool holds
    a_cancel_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CAN_RD || r_state == S_CAN_CHK || r_state == S_CAN_FREE)
        |-> (r_cnt <= 6'(POOL_ENTRIES)))
        else $error("cancel count beyond pool size");

endmodule

// ===== rtl/core/trqs_mem.sv =====
// ----------------------------------------------------------------------------
// trqs_mem
// entry store: payload memory and link memory, one write port each, one
// shared registered read port; links read as index order until written
// ----------------------------------------------------------------------------
module trqs_mem #(
    parameter int POOL_ENTRIES = trqs_pkg::POOL_ENTRIES_DEF,
    parameter int TICK_BITS    = trqs_pkg::TICK_BITS_DEF,
    parameter int TOKEN_BITS   = trqs_pkg::TOKEN_BITS_DEF,
    parameter int ARG_BITS     = trqs_pkg::ARG_BITS_DEF,
    localparam int AW          = $clog2(POOL_ENTRIES),
    localparam int PW          = $clog2(POOL_ENTRIES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_d_we,
    input  logic [AW-1:0]         i_d_addr,
    input  logic                  i_d_kind,
    input  logic [TOKEN_BITS-1:0] i_d_token,
    input  logic [ARG_BITS-1:0]   i_d_arg,
    input  logic                  i_d_managed,
    input  logic [TICK_BITS-1:0]  i_d_expiry,
    input  logic                  i_l_we,
    input  logic [AW-1:0]         i_l_addr,
    input  logic [PW-1:0]         i_l_link,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic                  o_kind,
    output logic [TOKEN_BITS-1:0] o_token,
    output logic [ARG_BITS-1:0]   o_arg,
    output logic                  o_managed,
    output logic [TICK_BITS-1:0]  o_expiry,
    output logic [PW-1:0]         o_link
);

    localparam int DW = 1 + TOKEN_BITS + ARG_BITS + 1 + TICK_BITS;

    logic [DW-1:0]           r_dmem [POOL_ENTRIES];
    logic [PW-1:0]           r_lmem [POOL_ENTRIES];
    logic [POOL_ENTRIES-1:0] r_lvalid;
    logic [DW-1:0]           r_dq;
    logic [PW-1:0]           r_lq;

    always_ff @(posedge i_clk) begin
        if (i_d_we) begin
            r_dmem[i_d_addr] <= {i_d_kind, i_d_token, i_d_arg, i_d_managed, i_d_expiry};
        end
        if (i_l_we) begin
            r_lmem[i_l_addr] <= i_l_link;
        end
        if (i_re) begin
            r_dq <= r_dmem[i_raddr];
            // unwritten link: reset chain points at the next index
            r_lq <= r_lvalid[i_raddr] ? r_lmem[i_raddr] : PW'(i_raddr) + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvalid <= '0;
        end else if (i_l_we) begin
            r_lvalid[i_l_addr] <= 1'b1;
        end
    end

    assign {o_kind, o_token, o_arg, o_managed, o_expiry} = r_dq;
    assign o_link = r_lq;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the timer and ready queue scheduler: commands are
// queued up front, driven with random gaps, and every accepted command is
// run through an in-bench scheduler model whose result beats are compared
// in order against the beats the core hands out
// ----------------------------------------------------------------------------
module tb_top;

    localparam int POOL     = trqs_pkg::POOL_ENTRIES_DEF;
    localparam int NIL      = POOL;
    localparam int WDOG_MAX = 4000;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] hnd;
        logic [15:0] evt;
        logic [31:0] arg;
        logic [31:0] dly;
        logic        mgd;
        bit          drain;     // pause here until every result is back
    } t_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  in_op = '0;
    logic [15:0] in_hnd = '0;
    logic [15:0] in_evt = '0;
    logic [31:0] in_arg = '0;
    logic [31:0] in_dly = '0;
    logic        in_mgd = 1'b0;
    logic        o_out_valid;
    logic        burst_stall = 1'b0;
    logic        long_hold = 1'b0;
    wire         out_stall = burst_stall | long_hold;
    logic [1:0]  o_kind, o_status;
    logic [15:0] o_out_handler, o_out_event;
    logic [31:0] o_out_argument, o_sleep_ticks;
    logic        o_release_arg, o_last;
    logic [5:0]  o_cancel_count;

    timer_and_ready_queue_scheduler_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_operation(in_op), .i_handler_id(in_hnd), .i_event_id(in_evt),
        .i_argument(in_arg), .i_delay_ticks(in_dly), .i_managed(in_mgd),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_kind(o_kind), .o_status(o_status), .o_out_handler(o_out_handler),
        .o_out_event(o_out_event), .o_out_argument(o_out_argument),
        .o_release_arg(o_release_arg), .o_cancel_count(o_cancel_count),
        .o_sleep_ticks(o_sleep_ticks), .o_last(o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // scheduler model state: one entry pool, three linked lists
    // ------------------------------------------------------------------
    logic        sch_kind [POOL];
    logic [15:0] sch_tok  [POOL];
    logic [31:0] sch_arg  [POOL];
    logic        sch_mgd  [POOL];
    logic [31:0] sch_exp  [POOL];
    int          sch_link [POOL];
    int          free_hd, rdy_hd, rdy_tl, tmr_hd;
    logic [31:0] now_tick;

    t_cmd              pend_q[$];
    trqs_pkg::t_result beats_due[$];
    trqs_pkg::t_result step_beats[$];

    int unsigned want_cnt = 0;     // beats predicted, bumped by the driver
    int unsigned got_cnt = 0;      // beats taken, bumped by the monitor
    int unsigned taken_cmds = 0;
    int unsigned errors = 0;
    bit          quiet = 1'b0;     // last part of the run: no idling

    function automatic void sched_reset();
        for (int i = 0; i < POOL; i++) sch_link[i] = i + 1;
        free_hd = 0;
        rdy_hd  = NIL;
        rdy_tl  = NIL;
        tmr_hd  = NIL;
        now_tick = '0;
    endfunction

    function automatic void emit_beat(logic [1:0] k, logic [1:0] st, logic [15:0] h,
                                      logic [15:0] ev, logic [31:0] a, logic rel,
                                      logic [5:0] cnt, logic [31:0] slp);
        trqs_pkg::t_result r;
        r = '{kind: k, status: st, handler: h, out_evt: ev, argument: a,
              release_arg: rel, cancel_count: cnt, sleep_len: slp, last: 1'b0};
        step_beats.push_back(r);
    endfunction

    function automatic int take_free();
        int e;
        e = free_hd;
        if (e == NIL) return NIL;
        free_hd = sch_link[e];
        sch_link[e] = NIL;
        return e;
    endfunction

    function automatic void give_free(int e);
        sch_link[e] = free_hd;
        free_hd = e;
    endfunction

    function automatic void ready_push(int e);
        sch_link[e] = NIL;
        if (rdy_tl != NIL) sch_link[rdy_tl] = e;
        else rdy_hd = e;
        rdy_tl = e;
    endfunction

    function automatic int drop_matches(inout int hd, input logic [15:0] tok,
                                        input logic [31:0] a);
        int cnt, prv, cur, nxt;
        cnt = 0;
        prv = NIL;
        cur = hd;
        while (cur != NIL) begin
            nxt = sch_link[cur];
            if (sch_kind[cur] == trqs_pkg::ENT_TASK && sch_tok[cur] == tok &&
                sch_arg[cur] == a) begin
                if (prv != NIL) sch_link[prv] = nxt;
                else hd = nxt;
                give_free(cur);
                cnt++;
            end else begin
                prv = cur;
            end
            cur = nxt;
        end
        return cnt;
    endfunction

    // work out the beats one command causes and queue them
    function automatic void sched_step(t_cmd c);
        int          e, prv, cur, cnt;
        logic [31:0] d, slp;
        step_beats.delete();
        case (c.op)
            trqs_pkg::OP_TICK: begin
                now_tick = now_tick + 32'd1;
                emit_beat(trqs_pkg::KIND_STATUS, trqs_pkg::ST_OK, '0, '0, '0, 1'b0, '0, '0);
            end
            trqs_pkg::OP_POST, trqs_pkg::OP_POST_DLY: begin
                if (c.hnd == '0) begin
                    emit_beat(trqs_pkg::KIND_STATUS, trqs_pkg::ST_NULL_HND,
                              '0, '0, '0, 1'b0, '0, '0);
                end else begin
                    e = take_free();
                    if (e == NIL) begin
                        emit_beat(trqs_pkg::KIND_STATUS, trqs_pkg::ST_POOL_FULL,
                                  '0, '0, '0, 1'b0, '0, '0);
                    end else begin
                        sch_kind[e] = trqs_pkg::ENT_TASK;
                        sch_tok[e]  = c.hnd;
                        sch_arg[e]  = c.arg;
                        sch_mgd[e]  = 1'b0;
                        if (c.op == trqs_pkg::OP_POST) ready_push(e);
                        else begin
                            // sorted insert, equal expiries stay in posting order
                            sch_exp[e] = now_tick + c.dly;
                            prv = NIL;
                            cur = tmr_hd;
                            while (cur != NIL) begin
                                d = sch_exp[cur] - sch_exp[e];
                                if (d != '0 && !d[31]) break;
                                prv = cur;
                                cur = sch_link[cur];
                            end
                            sch_link[e] = cur;
                            if (prv != NIL) sch_link[prv] = e;
                            else tmr_hd = e;
                        end
                        emit_beat(trqs_pkg::KIND_STATUS, trqs_pkg::ST_OK,
                                  '0, '0, '0, 1'b0, '0, '0);
                    end
                end
            end
            trqs_pkg::OP_EMIT: begin
                e = take_free();
                if (e == NIL) begin
                    emit_beat(trqs_pkg::KIND_STATUS, trqs_pkg::ST_POOL_FULL,
                              '0, c.evt, c.arg, c.mgd, '0, '0);
                end else begin
                    sch_kind[e] = trqs_pkg::ENT_EVENT;
                    sch_tok[e]  = c.evt;
                    sch_arg[e]  = c.arg;
                    sch_mgd[e]  = c.mgd;
                    ready_push(e);
                    emit_beat(trqs_pkg::KIND_STATUS, trqs_pkg::ST_OK, '0, '0, '0, 1'b0, '0, '0);
                end
            end
            trqs_pkg::OP_CANCEL: begin
                if (c.hnd == '0) begin
                    emit_beat(trqs_pkg::KIND_STATUS, trqs_pkg::ST_NULL_HND,
                              '0, '0, '0, 1'b0, '0, '0);
                end else begin
                    cnt = drop_matches(tmr_hd, c.hnd, c.arg);
                    cnt += drop_matches(rdy_hd, c.hnd, c.arg);
                    rdy_tl = NIL;
                    cur = rdy_hd;
                    while (cur != NIL) begin
                        rdy_tl = cur;
                        cur = sch_link[cur];
                    end
                    emit_beat(trqs_pkg::KIND_STATUS, trqs_pkg::ST_OK,
                              '0, '0, '0, 1'b0, cnt[5:0], '0);
                end
            end
            trqs_pkg::OP_RUN: begin
                while (tmr_hd != NIL) begin
                    d = now_tick - sch_exp[tmr_hd];
                    if (d[31]) break;
                    e = tmr_hd;
                    tmr_hd = sch_link[e];
                    ready_push(e);
                end
                cur = rdy_hd;
                rdy_hd = NIL;
                rdy_tl = NIL;
                while (cur != NIL) begin
                    e = sch_link[cur];
                    if (sch_kind[cur] == trqs_pkg::ENT_TASK)
                        emit_beat(trqs_pkg::KIND_TASK, trqs_pkg::ST_OK, sch_tok[cur], '0,
                                  sch_arg[cur], 1'b0, '0, '0);
                    else
                        emit_beat(trqs_pkg::KIND_EVENT, trqs_pkg::ST_OK, '0, sch_tok[cur],
                                  sch_arg[cur], sch_mgd[cur], '0, '0);
                    give_free(cur);
                    cur = e;
                end
                slp = '1;
                if (tmr_hd != NIL) begin
                    d = sch_exp[tmr_hd] - now_tick;
                    slp = (d != '0 && !d[31]) ? d : 32'd0;
                end
                emit_beat(trqs_pkg::KIND_SUMMARY, trqs_pkg::ST_OK, '0, '0, '0, 1'b0, '0, slp);
            end
            default: ;   // unused codes: nothing happens
        endcase
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_cmd(logic [2:0] op, logic [15:0] h, logic [15:0] ev,
                                    logic [31:0] a, logic [31:0] dl, logic m);
        t_cmd c;
        c = '{op: op, hnd: h, evt: ev, arg: a, dly: dl, mgd: m, drain: 1'b0};
        pend_q.push_back(c);
    endfunction

    function automatic void add_drain();
        t_cmd c;
        c = '{op: trqs_pkg::OP_TICK, hnd: '0, evt: '0, arg: '0, dly: '0, mgd: 1'b0,
              drain: 1'b1};
        pend_q.push_back(c);
    endfunction

    // small token and argument sets so that cancels hit often
    function automatic logic [15:0] pick_hnd();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0) return 16'd0;
        if (r < 9) return 16'($urandom_range(1, 3));
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_arg();
        return ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 2)) : 32'($urandom);
    endfunction

    function automatic logic [31:0] pick_dly();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 32'($urandom_range(0, 4));
        if (r < 9) return 32'($urandom_range(5, 40));
        return 32'($urandom);
    endfunction

    function automatic void build_stimulus();
        int n, r, k;
        // directed: every op, field extremes and corner cases
        add_cmd(trqs_pkg::OP_RUN, '0, '0, '0, '0, 1'b0);            // run on empty scheduler
        add_cmd(trqs_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, '1, '1, 1'b1);
        add_cmd(trqs_pkg::OP_POST, '0, '0, 32'h1234, '0, 1'b0);     // null handler
        add_cmd(trqs_pkg::OP_POST_DLY, '0, '0, '0, 32'd5, 1'b0);    // null handler, delayed
        add_cmd(trqs_pkg::OP_CANCEL, '0, '0, '0, '0, 1'b0);         // null handler cancel
        add_cmd(trqs_pkg::OP_POST, 16'hFFFF, '0, '1, '0, 1'b0);
        add_cmd(trqs_pkg::OP_POST, 16'h0001, '0, '0, '0, 1'b0);
        add_cmd(trqs_pkg::OP_EMIT, '0, 16'hFFFF, '1, '0, 1'b1);
        add_cmd(trqs_pkg::OP_EMIT, '0, 16'h0000, '0, '0, 1'b0);
        add_cmd(trqs_pkg::OP_POST_DLY, 16'h0002, '0, 32'd7, 32'd3, 1'b0);
        add_cmd(trqs_pkg::OP_POST_DLY, 16'h0003, '0, 32'd7, 32'd3, 1'b0); // equal expiry
        add_cmd(trqs_pkg::OP_POST_DLY, 16'h0004, '0, 32'd8, 32'd0, 1'b0); // due now
        add_cmd(trqs_pkg::OP_POST_DLY, 16'h0005, '0, 32'd9, '1, 1'b0);    // one tick ago
        add_cmd(trqs_pkg::OP_POST_DLY, 16'h0006, '0, 32'd9, 32'h7FFF_FFFF, 1'b0);
        add_cmd(trqs_pkg::OP_POST_DLY, 16'h0007, '0, 32'd9, 32'h8000_0000, 1'b0);
        add_cmd(trqs_pkg::OP_RUN, '0, '0, '0, '0, 1'b0);
        add_cmd(trqs_pkg::OP_POST, 16'h0002, '0, 32'd7, '0, 1'b0);
        add_cmd(trqs_pkg::OP_CANCEL, 16'h0002, '0, 32'd7, '0, 1'b0); // timer and ready list
        add_cmd(trqs_pkg::OP_CANCEL, 16'h0009, '0, 32'd7, '0, 1'b0); // hits nothing
        add_cmd(trqs_pkg::OP_TICK, '0, '0, '0, '0, 1'b0);
        add_cmd(trqs_pkg::OP_TICK, '0, '0, '0, '0, 1'b0);
        add_cmd(trqs_pkg::OP_TICK, '0, '0, '0, '0, 1'b0);
        add_cmd(3'd6, '0, '0, '0, '0, 1'b0);                           // unused codes
        add_cmd(3'd7, 16'hFFFF, 16'hFFFF, '1, '1, 1'b1);
        add_cmd(trqs_pkg::OP_RUN, '0, '0, '0, '0, 1'b0);
        add_drain();

        // random: mostly scheduler traffic, now and then a pool flood
        n = 0;
        while (n < 75) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                // fill the pool past its end, then drain it with a run
                for (k = 0; k < POOL + 2; k++) begin
                    if ($urandom_range(0, 2) == 0)
                        add_cmd(trqs_pkg::OP_EMIT, '0, 16'($urandom), 32'($urandom), '0,
                                1'($urandom));
                    else
                        add_cmd($urandom_range(0, 1) ? trqs_pkg::OP_POST : trqs_pkg::OP_POST_DLY,
                                16'($urandom_range(1, 3)), '0, pick_arg(), pick_dly(), 1'b0);
                end
                add_cmd(trqs_pkg::OP_EMIT, '0, 16'($urandom), 32'($urandom), '0, 1'($urandom));
                add_cmd(trqs_pkg::OP_CANCEL, 16'($urandom_range(1, 3)), '0, pick_arg(), '0, 1'b0);
                add_cmd(trqs_pkg::OP_RUN, '0, '0, '0, '0, 1'b0);
                n += POOL + 5;
            end else begin
                if (r < 24) add_cmd(trqs_pkg::OP_TICK, 16'($urandom), 16'($urandom),
                                    32'($urandom), 32'($urandom), 1'($urandom));
                else if (r < 42) add_cmd(trqs_pkg::OP_POST, pick_hnd(), 16'($urandom),
                                         pick_arg(), 32'($urandom), 1'($urandom));
                else if (r < 60) add_cmd(trqs_pkg::OP_POST_DLY, pick_hnd(), 16'($urandom),
                                         pick_arg(), pick_dly(), 1'($urandom));
                else if (r < 72) add_cmd(trqs_pkg::OP_EMIT, 16'($urandom), 16'($urandom),
                                         pick_arg(), 32'($urandom), 1'($urandom));
                else if (r < 82) add_cmd(trqs_pkg::OP_CANCEL, pick_hnd(), 16'($urandom),
                                         pick_arg(), 32'($urandom), 1'($urandom));
                else if (r < 98) add_cmd(trqs_pkg::OP_RUN, 16'($urandom), 16'($urandom),
                                         32'($urandom), 32'($urandom), 1'($urandom));
                else add_cmd(3'($urandom_range(6, 7)), 16'($urandom), 16'($urandom),
                             32'($urandom), 32'($urandom), 1'($urandom));
                n++;
            end
            if (n > 50 && n < 56) add_drain();
        end
        add_cmd(trqs_pkg::OP_RUN, '0, '0, '0, '0, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // driver: command beats off the pending queue with random gaps
    // ------------------------------------------------------------------
    int  gap_left = 0;
    bit  draining = 1'b0;

    always @(posedge i_clk) begin
        t_cmd c;
        bit   fire;
        fire = 1'b0;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                c = '{op: in_op, hnd: in_hnd, evt: in_evt, arg: in_arg, dly: in_dly,
                      mgd: in_mgd, drain: 1'b0};
                sched_step(c);
                want_cnt   <= want_cnt + step_beats.size();
                taken_cmds <= taken_cmds + 1;
                if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 7);
            end
            if (in_valid && o_in_stall) begin
                // hold the beat
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else begin
                // a drain marker waits until every predicted beat is back
                while (pend_q.size() > 0 && pend_q[0].drain && !draining) begin
                    void'(pend_q.pop_front());
                    draining = 1'b1;
                end
                if (draining && beats_due.size() == 0 && want_cnt == got_cnt)
                    draining = 1'b0;
                if (!draining && pend_q.size() > 0) begin
                    c = pend_q.pop_front();
                    in_op  <= c.op;
                    in_hnd <= c.hnd;
                    in_evt <= c.evt;
                    in_arg <= c.arg;
                    in_dly <= c.dly;
                    in_mgd <= c.mgd;
                    fire = 1'b1;
                end
                in_valid <= fire;
            end
            quiet <= (pend_q.size() < 15);
        end
    end

    // ------------------------------------------------------------------
    // result side stall: random bursts, plus one long hold-off while the
    // sender keeps offering so the core backs up into its command channel
    // ------------------------------------------------------------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            burst_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            burst_stall <= (stall_left != 0);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 7);
            burst_stall <= 1'b1;
        end else begin
            burst_stall <= 1'b0;
        end
    end

    int  hold_cycles = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (i_rst_n && !hold_done && taken_cmds >= 45) begin
            if (hold_cycles < 300) begin
                hold_cycles++;
                long_hold <= 1'b1;
            end else begin
                long_hold <= 1'b0;
                hold_done = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: each result beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        trqs_pkg::t_result act, exp_b;
        if (i_rst_n && o_out_valid && !out_stall) begin
            act = '{kind: o_kind, status: o_status, handler: o_out_handler,
                    out_evt: o_out_event, argument: o_out_argument,
                    release_arg: o_release_arg, cancel_count: o_cancel_count,
                    sleep_len: o_sleep_ticks, last: o_last};
            got_cnt <= got_cnt + 1;
            if (beats_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", act);
            end else begin
                exp_b = beats_due.pop_front();
                if (act.kind !== exp_b.kind || act.status !== exp_b.status ||
                    act.handler !== exp_b.handler || act.out_evt !== exp_b.out_evt ||
                    act.argument !== exp_b.argument ||
                    act.release_arg !== exp_b.release_arg ||
                    act.cancel_count !== exp_b.cancel_count ||
                    act.sleep_len !== exp_b.sleep_len || act.last !== exp_b.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("beat mismatch\n  expected %p\n  actual   %p", exp_b, act);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles with no beat taken on either channel
    // ------------------------------------------------------------------
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || !i_rst_n)
            idle_cycles = 0;
        else if (++idle_cycles >= WDOG_MAX) begin
            $display("timer_and_ready_queue_scheduler_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // reset, stimulus, end of run
    // ------------------------------------------------------------------
    initial begin
        sched_reset();
        build_stimulus();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (pend_q.size() != 0 || in_valid || draining);
        do @(posedge i_clk);
        while (beats_due.size() != 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && beats_due.size() == 0 && !o_out_valid)
            $display("timer_and_ready_queue_scheduler_core regression: pass");
        else
            $display("timer_and_ready_queue_scheduler_core regression: fail");
        $finish;
    end

endmodule
